### src/lbcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcg_pkg
// Types and constants shared by the LED blink code generator.
// ----------------------------------------------------------------------------
package lbcg_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ON    = 2'd1,
        PH_OFF   = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_BLINK_GOAL = 2'd0,
        REG_ON_TIME    = 2'd1,
        REG_OFF_TIME   = 2'd2,
        REG_PAUSE_TIME = 2'd3
    } reg_index_t;

    localparam int GOAL_W  = 8;
    localparam int TIME_W  = 16;
    localparam int TALLY_W = 4;

    localparam logic [GOAL_W-1:0] GOAL_RESET       = 8'd0;
    localparam logic [TIME_W-1:0] ON_TIME_RESET    = 16'd200;
    localparam logic [TIME_W-1:0] OFF_TIME_RESET   = 16'd200;
    localparam logic [TIME_W-1:0] PAUSE_TIME_RESET = 16'd1000;

    localparam logic [GOAL_W-1:0] FULL_ON_GOAL = 8'd10;
    localparam logic [TIME_W-1:0] RECHECK_MS   = 16'd500;

    typedef struct packed {
        logic [GOAL_W-1:0] blink_goal;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] pause_time;
    } blink_cfg_t;

    typedef struct packed {
        logic               pin_level;
        logic [1:0]         phase_code;
        logic [TALLY_W-1:0] blinks_done;
    } status_t;

    function automatic logic [TIME_W-1:0] delay_of(input logic [TIME_W-1:0] ms);
        delay_of = (ms == '0) ? TIME_W'(1) : ms;
    endfunction

endpackage

### src/lbcg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcg_if
// Handshake channels of the LED blink code generator: tick, status, config.
// ----------------------------------------------------------------------------
interface lbcg_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface lbcg_status_if;
    logic       valid;
    logic       ready;
    logic       pin_level;
    logic [1:0] phase_code;
    logic [3:0] blinks_done;

    modport source (output valid, output pin_level, output phase_code,
                    output blinks_done, input ready);
    modport sink   (input valid, input pin_level, input phase_code,
                    input blinks_done, output ready);
endinterface

interface lbcg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/lbcg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcg_cfg_regs
// Configuration registers: blink goal and the on, off and pause times.
// ----------------------------------------------------------------------------
module lbcg_cfg_regs
    import lbcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lbcg_cfg_if.sink    cfg,
    output blink_cfg_t  regs
);

    blink_cfg_t regs_reg;
    blink_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_BLINK_GOAL: regs_next.blink_goal = cfg.data[GOAL_W-1:0];
                REG_ON_TIME:    regs_next.on_time    = cfg.data;
                REG_OFF_TIME:   regs_next.off_time   = cfg.data;
                REG_PAUSE_TIME: regs_next.pause_time = cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.blink_goal <= GOAL_RESET;
            regs_reg.on_time    <= ON_TIME_RESET;
            regs_reg.off_time   <= OFF_TIME_RESET;
            regs_reg.pause_time <= PAUSE_TIME_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

### src/lbcg_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcg_sequencer
// Phase machine, blink tally and millisecond countdown of the blink code.
// ----------------------------------------------------------------------------
module lbcg_sequencer
    import lbcg_pkg::*;
#(
    parameter bit ACTIVE_LEVEL = 1'b1
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  blink_cfg_t regs,
    input  logic       advance,
    input  logic       tick,
    output status_t    status_next
);

    phase_t             phase_reg,     phase_next;
    logic [TALLY_W-1:0] tally_reg,     tally_next;
    logic [TIME_W-1:0]  countdown_reg, countdown_next;
    logic               lit_reg,       lit_next;
    logic [TALLY_W-1:0] tally_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tally_reg     <= '0;
            countdown_reg <= TIME_W'(1);
            lit_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            tally_reg     <= tally_next;
            countdown_reg <= countdown_next;
            lit_reg       <= lit_next;
        end
    end

    assign tally_inc = tally_reg + TALLY_W'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        tally_next     = tally_reg;
        countdown_next = countdown_reg;
        lit_next       = lit_reg;
        if (tick)
        begin
            if (countdown_reg > TIME_W'(1))
            begin
                countdown_next = countdown_reg - TIME_W'(1);
            end
            else if (regs.blink_goal == '0)
            begin
                lit_next       = 1'b0;
                phase_next     = PH_IDLE;
                countdown_next = RECHECK_MS;
            end
            else if (regs.blink_goal >= FULL_ON_GOAL)
            begin
                lit_next       = 1'b1;
                phase_next     = PH_IDLE;
                countdown_next = RECHECK_MS;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ON:
                    begin
                        lit_next       = 1'b0;
                        phase_next     = PH_OFF;
                        countdown_next = delay_of(regs.off_time);
                    end
                    PH_OFF:
                    begin
                        tally_next = tally_inc;
                        if (GOAL_W'(tally_inc) >= regs.blink_goal)
                        begin
                            phase_next     = PH_PAUSE;
                            countdown_next = delay_of(regs.pause_time);
                        end
                        else
                        begin
                            lit_next       = 1'b1;
                            phase_next     = PH_ON;
                            countdown_next = delay_of(regs.on_time);
                        end
                    end
                    PH_IDLE, PH_PAUSE:
                    begin
                        tally_next     = '0;
                        lit_next       = 1'b1;
                        phase_next     = PH_ON;
                        countdown_next = delay_of(regs.on_time);
                    end
                endcase
            end
        end

        status_next.pin_level   = lit_next ? ACTIVE_LEVEL : ~ACTIVE_LEVEL;
        status_next.phase_code  = 2'(phase_next);
        status_next.blinks_done = tally_next;
    end

endmodule

### src/lbcg_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcg_out_reg
// Result register between the sequencer and the status channel.
// ----------------------------------------------------------------------------
module lbcg_out_reg
    import lbcg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  status_t       status_in,
    output logic          space,
    lbcg_status_if.source status
);

    logic    valid_reg, valid_next;
    status_t data_reg;

    assign space = !valid_reg || status.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= status_in;
        end
    end

    assign status.valid       = valid_reg;
    assign status.pin_level   = data_reg.pin_level;
    assign status.phase_code  = data_reg.phase_code;
    assign status.blinks_done = data_reg.blinks_done;

endmodule

### src/led_blink_code_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_code_generator
// Status LED blink code generator driven by millisecond tick items.
// ----------------------------------------------------------------------------
// Each tick item yields one status item in the next cycle showing the state
// after that tick. One item is taken every clock; the tick channel stalls
// only while the status register is full and not being taken. Configuration
// writes complete in the cycle they are offered and take effect on the next
// tick item.
module led_blink_code_generator
    import lbcg_pkg::*;
#(
    parameter bit ACTIVE_LEVEL = 1'b1
)
(
    input  logic          clk,
    input  logic          rst_n,
    lbcg_tick_if.sink     ticks,
    lbcg_status_if.source status,
    lbcg_cfg_if.sink      cfg
);

    blink_cfg_t regs;
    status_t    status_next;
    logic       space;
    logic       accept;

    assign ticks.ready = space;
    assign accept      = ticks.valid && space;

    lbcg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lbcg_sequencer #(
        .ACTIVE_LEVEL (ACTIVE_LEVEL)
    ) u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .advance     (accept),
        .tick        (ticks.tick),
        .status_next (status_next)
    );

    lbcg_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .status_in (status_next),
        .space     (space),
        .status    (status)
    );

endmodule

### dv/led_blink_code_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_code_generator_test
// Self-checking bench for the status LED blink code generator. Tick items go
// in with random gaps and every status item coming back is matched, field by
// field, against a cycle-free model of the phase, blink count, countdown and
// LED level. Runs cover blink codes with short and zero delays, the goal
// lowered mid-cycle, the always-off and always-on recheck, register
// extremes, a long receiver hold-off and a full drain mid-stream.
// ----------------------------------------------------------------------------
module led_blink_code_generator_test;
    import lbcg_pkg::*;

    localparam bit LED_ACTIVE  = 1'b1;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;

    lbcg_tick_if   tick_ch();
    lbcg_status_if status_ch();
    lbcg_cfg_if    cfg_ch();

    led_blink_code_generator #(
        .ACTIVE_LEVEL(LED_ACTIVE)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .ticks (tick_ch),
        .status(status_ch),
        .cfg   (cfg_ch)
    );

    // model registers and state
    logic [GOAL_W-1:0]  goal_reg;
    logic [TIME_W-1:0]  on_ms;
    logic [TIME_W-1:0]  off_ms;
    logic [TIME_W-1:0]  pause_len;
    phase_t             led_phase;
    logic [TALLY_W-1:0] blinks_seen;
    logic [TIME_W-1:0]  ms_left;
    logic               led_lit;

    status_t status_due[$];
    int      mismatch_count;
    int      cycle_count;
    int      pend_gap;
    bit      tick_up;
    bit      no_gaps;
    int      hold_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [TIME_W-1:0] ms_or_one(input logic [TIME_W-1:0] ms);
        return (ms == '0) ? TIME_W'(1) : ms;
    endfunction

    function automatic status_t next_status(input logic tick_bit);
        status_t s;
        if (tick_bit)
        begin
            if (ms_left <= 1)
            begin
                if (goal_reg == '0)
                begin
                    led_lit   = 1'b0;
                    led_phase = PH_IDLE;
                    ms_left   = RECHECK_MS;
                end
                else if (goal_reg >= FULL_ON_GOAL)
                begin
                    led_lit   = 1'b1;
                    led_phase = PH_IDLE;
                    ms_left   = RECHECK_MS;
                end
                else
                begin
                    case (led_phase)
                        PH_ON:
                        begin
                            led_lit   = 1'b0;
                            led_phase = PH_OFF;
                            ms_left   = ms_or_one(off_ms);
                        end
                        PH_OFF:
                        begin
                            blinks_seen = blinks_seen + 1'b1;
                            if (blinks_seen >= goal_reg)
                            begin
                                led_phase = PH_PAUSE;
                                ms_left   = ms_or_one(pause_len);
                            end
                            else
                            begin
                                led_lit   = 1'b1;
                                led_phase = PH_ON;
                                ms_left   = ms_or_one(on_ms);
                            end
                        end
                        default:
                        begin
                            blinks_seen = '0;
                            led_lit     = 1'b1;
                            led_phase   = PH_ON;
                            ms_left     = ms_or_one(on_ms);
                        end
                    endcase
                end
            end
            else
            begin
                ms_left = ms_left - 1'b1;
            end
        end
        s.pin_level   = led_lit ? LED_ACTIVE : ~LED_ACTIVE;
        s.phase_code  = led_phase;
        s.blinks_done = blinks_seen;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_tick(input logic t);
        if (pend_gap > 0)
        begin
            repeat (pend_gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= t;
        tick_up = 1'b1;
        do @(posedge clk); while (!tick_ch.ready);
        status_due.push_back(next_status(t));
        pend_gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (pend_gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            tick_up = 1'b0;
        end
    endtask

    task automatic tick_idle();
        if (tick_up)
        begin
            tick_ch.valid <= 1'b0;
            tick_up = 1'b0;
        end
    endtask

    task automatic wait_drained();
        tick_idle();
        while (status_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [TIME_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_BLINK_GOAL: goal_reg  = val[GOAL_W-1:0];
            REG_ON_TIME:    on_ms     = val;
            REG_OFF_TIME:   off_ms    = val;
            REG_PAUSE_TIME: pause_len = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [GOAL_W-1:0] goal, input logic [TIME_W-1:0] on_t,
                             input logic [TIME_W-1:0] off_t,
                             input logic [TIME_W-1:0] pause_t);
        wait_drained();
        write_reg(REG_BLINK_GOAL, {8'($urandom_range(0, 255)), goal});
        write_reg(REG_ON_TIME, on_t);
        write_reg(REG_OFF_TIME, off_t);
        write_reg(REG_PAUSE_TIME, pause_t);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_ms(input int n);
        int sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_tick(1'b0);
            end
            else
            begin
                send_tick(1'b1);
                sent++;
            end
        end
    endtask

    function automatic logic [TIME_W-1:0] pick_ms();
        return ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 40))
                                           : TIME_W'($urandom_range(0, 4));
    endfunction

    task automatic test_blink_code();
        logic pattern [16];
        pattern = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
                    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
        configure(8'd3, 16'd0, 16'd1, 16'd2);
        foreach (pattern[i])
        begin
            send_tick(pattern[i]);
        end
    endtask

    task automatic test_goal_lowered();
        configure(8'd6, 16'd1, 16'd1, 16'd3);
        run_ms(6);
        configure(8'd2, 16'd1, 16'd1, 16'd3);
        run_ms(4);
    endtask

    task automatic test_random_blinking();
        for (int p = 0; p < 6; p++)
        begin
            configure(8'($urandom_range(1, 9)), pick_ms(), pick_ms(), pick_ms());
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 40; i++)
            begin
                if (p == 2 && i == 10)
                begin
                    hold_cycles = 300;
                end
                if (p == 4 && i == 20)
                begin
                    wait_drained();
                end
                send_tick($urandom_range(0, 6) != 0);
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_steady_levels();
        configure(8'd0, 16'd0, 16'd0, 16'd0);
        run_ms(45);
        configure(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_ms(100);
        configure(FULL_ON_GOAL, 16'($urandom), 16'($urandom), 16'($urandom));
        while (!led_lit)
        begin
            send_tick($urandom_range(0, 7) != 0);
        end
        run_ms(20);
    endtask

    // status receiver
    initial
    begin
        int wait_cycles;
        status_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = hold_cycles + (no_gaps ? 0 : $urandom_range(0, 19));
            hold_cycles = 0;
            if (wait_cycles > 0)
            begin
                status_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            status_ch.ready <= 1'b1;
            do @(posedge clk); while (!status_ch.valid);
        end
    end

    // status checker
    initial
    begin
        status_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && status_ch.valid && status_ch.ready)
            begin
                if (status_due.size() == 0)
                begin
                    report_mismatch("status item with none due", status_ch.phase_code, -1);
                end
                else
                begin
                    want = status_due.pop_front();
                    if (status_ch.pin_level !== want.pin_level)
                        report_mismatch("pin_level", status_ch.pin_level, want.pin_level);
                    if (status_ch.phase_code !== want.phase_code)
                        report_mismatch("phase_code", status_ch.phase_code, want.phase_code);
                    if (status_ch.blinks_done !== want.blinks_done)
                        report_mismatch("blinks_done", status_ch.blinks_done,
                                        want.blinks_done);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d status items due",
                         cycle_count, status_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        pend_gap       = 0;
        tick_up        = 1'b0;
        no_gaps        = 1'b0;
        hold_cycles    = 0;
        goal_reg       = GOAL_RESET;
        on_ms          = ON_TIME_RESET;
        off_ms         = OFF_TIME_RESET;
        pause_len      = PAUSE_TIME_RESET;
        led_phase      = PH_IDLE;
        blinks_seen    = '0;
        ms_left        = TIME_W'(1);
        led_lit        = 1'b0;
        rst_n         <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.tick  <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_BLINK_GOAL;
        cfg_ch.data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_blink_code();
        test_goal_lowered();
        test_random_blinking();
        test_steady_levels();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
